// ===== src/ar1ce_pkg.sv =====
// Shared types and constants for the AR(1) coefficient estimator.
package ar1ce_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned PROD_W    = 2 * SAMPLE_W;
  localparam int unsigned ENERGY_W  = 42;
  localparam int unsigned CROSS_W   = 43;
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned STATUS_W  = 2;

  // quotient bits resolved by the divider; anything at or above 2^QUO_W is overflow
  localparam int unsigned QUO_W     = COEF_W + 1;
  localparam int unsigned CNT_W     = $clog2(QUO_W);
  // dividend 2*(|cross| << FRAC_BITS) + energy
  localparam int unsigned REM_W     = CROSS_W + FRAC_BITS + 1;
  // divisor 2*energy
  localparam int unsigned DEN_W     = ENERGY_W + 1;
  localparam int unsigned DSH_W     = DEN_W + QUO_W - 1;
  localparam int unsigned OVF_W     = DEN_W + QUO_W;

  localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'((1 << (COEF_W - 1)) - 1);
  localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(1 << (COEF_W - 1));

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SAT  = 2'd1,
    STATUS_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic take;      // input transfer this cycle
    logic div_load;  // set up dividend, divisor and flags
    logic div_step;  // one restoring division step
    logic out_load;  // write result register and clear the sums
  } cmd_t;

  typedef struct packed {
    logic out_busy;  // result register holds a result that is not taken this cycle
  } sts_t;

endpackage

// ===== src/ar1_coefficient_estimator_unit.sv =====
// Top level of the AR(1) least-squares coefficient estimator.
//
// Input stream: one signed 16-bit sample per transfer on s_axis_tdata, with
// s_axis_tlast on the final sample of a series. While a series runs, a
// transfer is taken every cycle: each sample costs two 16x16 multiplies
// (registered) and two saturating accumulates in the following cycle.
// On the transfer that carries tlast, s_axis_tready drops. The block flushes
// the last products, sets up the divider, runs a restoring divider one
// quotient bit per cycle, then writes the result register: the result appears
// and s_axis_tready returns in the same cycle. The serial divider sets the
// length of that wait.
// Output stream: one transfer per series, m_axis_tdata = Q3.12 coefficient and
// status (ok, saturated, zero denominator). The result register frees the input
// side: a new series streams in while a result waits. If the receiver stalls
// and the next result is ready, the block holds in its write step with
// s_axis_tready low until the register is taken.
// Reset (async, active low) clears the sums, the sample history, the sequencer
// and m_axis_tvalid.
module ar1_coefficient_estimator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [15:0] coefficient, [17:16] status, [23:18] zero
);

  ar1ce_pkg::cmd_t cmd;
  ar1ce_pkg::sts_t sts;
  logic [ar1ce_pkg::COEF_W-1:0]   coef;
  logic [ar1ce_pkg::STATUS_W-1:0] status;

  ar1ce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ar1ce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .coef_o      (coef),
    .status_o    (status)
  );

  assign m_axis_tdata = {6'b000000, status, coef};

endmodule

// ===== src/ar1ce_ctrl.sv =====
// Sequencer for the AR(1) estimator: accumulate, flush, divide, write result.
module ar1ce_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  ar1ce_pkg::sts_t  sts_i,
  output ar1ce_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_ACCUM,
    S_FLUSH,
    S_LOAD,
    S_DIV,
    S_WRITE
  } state_e;

  state_e state_q, state_d;
  logic [ar1ce_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic take;

  assign in_ready_o = (state_q == S_ACCUM);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.take = take;
    unique case (state_q)
      S_ACCUM: begin
        if (take && in_last_i) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == ar1ce_pkg::CNT_W'(ar1ce_pkg::QUO_W - 1)) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_ACCUM;
        end
      end
      default: state_d = S_ACCUM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACCUM;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== src/ar1ce_dp.sv =====
// Datapath: product registers, saturating sums, serial divider, result register.
module ar1ce_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ar1ce_pkg::cmd_t                     cmd_i,
  output ar1ce_pkg::sts_t                     sts_o,
  input  logic signed [ar1ce_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ar1ce_pkg::COEF_W-1:0]        coef_o,
  output logic [ar1ce_pkg::STATUS_W-1:0]      status_o
);

  localparam int unsigned EW = ar1ce_pkg::ENERGY_W;
  localparam int unsigned CW = ar1ce_pkg::CROSS_W;
  localparam int unsigned PW = ar1ce_pkg::PROD_W;

  // multiply stage
  logic signed [ar1ce_pkg::SAMPLE_W-1:0] prev_q;
  logic                                  have_prev_q;
  logic signed [PW-1:0]                  pe_q, pc_q;
  logic                                  pv_q;

  // sums
  logic [EW-1:0]        energy_q;
  logic signed [CW-1:0] cross_q;
  logic [EW:0]          e_sum;
  logic [CW:0]          c_sum;
  logic [EW-1:0]        e_sat;
  logic [CW-1:0]        c_sat;

  // divider
  logic [ar1ce_pkg::REM_W-1:0] rem_q;
  logic [ar1ce_pkg::DSH_W-1:0] dsh_q;
  logic [ar1ce_pkg::QUO_W-1:0] quo_q;
  logic                        neg_q, ovf_q, zero_q;
  logic [CW-1:0]               mag;
  logic [ar1ce_pkg::REM_W-1:0] num;
  logic [ar1ce_pkg::DEN_W-1:0] den;
  logic                        fits;

  // result
  logic                                out_valid_q;
  logic [ar1ce_pkg::COEF_W-1:0]        coef_q, coef_d;
  logic [ar1ce_pkg::STATUS_W-1:0]      status_q;
  ar1ce_pkg::status_e                  status_d;
  logic [ar1ce_pkg::QUO_W-1:0]         neg_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      pv_q        <= 1'b0;
    end else begin
      pv_q <= cmd_i.take && have_prev_q;
      if (cmd_i.take) begin
        prev_q      <= sample_i;
        have_prev_q <= !last_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pe_q <= prev_q * prev_q;
      pc_q <= sample_i * prev_q;
    end
  end

  // energy grows only; cross clamps to the signed CW-bit range
  assign e_sum = {1'b0, energy_q} + (EW + 1)'(pe_q[PW-2:0]);
  assign c_sum = {cross_q[CW-1], cross_q} + (CW + 1)'(pc_q);
  assign e_sat = e_sum[EW] ? '1 : e_sum[EW-1:0];

  always_comb begin
    if (c_sum[CW] == c_sum[CW-1]) begin
      c_sat = c_sum[CW-1:0];
    end else if (c_sum[CW]) begin
      c_sat = {1'b1, {(CW - 1){1'b0}}};
    end else begin
      c_sat = {1'b0, {(CW - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= '0;
      cross_q  <= '0;
    end else if (cmd_i.out_load) begin
      energy_q <= '0;
      cross_q  <= '0;
    end else if (pv_q) begin
      energy_q <= e_sat;
      cross_q  <= c_sat;
    end
  end

  // dividend carries the half-divisor for round-half-away rounding
  assign mag = cross_q[CW-1] ? CW'(-cross_q) : cross_q;
  assign num = {mag, {(ar1ce_pkg::FRAC_BITS + 1){1'b0}}} + ar1ce_pkg::REM_W'(energy_q);
  assign den = {energy_q, 1'b0};
  assign fits = ({3'b000, rem_q} >= dsh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q  <= num;
      dsh_q  <= {den, {(ar1ce_pkg::QUO_W - 1){1'b0}}};
      quo_q  <= '0;
      neg_q  <= cross_q[CW-1];
      zero_q <= (energy_q == '0);
      ovf_q  <= (ar1ce_pkg::OVF_W'(num) >= {den, {ar1ce_pkg::QUO_W{1'b0}}});
    end else if (cmd_i.div_step) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q[ar1ce_pkg::REM_W-1:0];
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[ar1ce_pkg::QUO_W-2:0], fits};
    end
  end

  assign neg_quo = -quo_q;

  always_comb begin
    coef_d   = '0;
    status_d = ar1ce_pkg::STATUS_OK;
    if (zero_q) begin
      status_d = ar1ce_pkg::STATUS_ZERO;
    end else if (!neg_q) begin
      if (ovf_q || quo_q > ar1ce_pkg::POS_LIMIT) begin
        coef_d   = ar1ce_pkg::POS_LIMIT[ar1ce_pkg::COEF_W-1:0];
        status_d = ar1ce_pkg::STATUS_SAT;
      end else begin
        coef_d = quo_q[ar1ce_pkg::COEF_W-1:0];
      end
    end else begin
      if (ovf_q || quo_q > ar1ce_pkg::NEG_LIMIT) begin
        coef_d   = ar1ce_pkg::NEG_LIMIT[ar1ce_pkg::COEF_W-1:0];
        status_d = ar1ce_pkg::STATUS_SAT;
      end else begin
        coef_d = neg_quo[ar1ce_pkg::COEF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      coef_q   <= coef_d;
      status_q <= status_d;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign coef_o         = coef_q;
  assign status_o       = status_q;

endmodule

// ===== src/ar1ce_checker.sv =====
// Port-level checks for the AR(1) estimator, bound to the top level.
module ar1ce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // held result stays put while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // series end closes the input right after the last sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input open right after last sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17:16] == ar1ce_pkg::STATUS_ZERO
      |-> m_axis_tdata[15:0] == 16'h0000)
    else $error("zero denominator with nonzero coefficient");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17:16] == ar1ce_pkg::STATUS_SAT
      |-> m_axis_tdata[15:0] == 16'h7fff || m_axis_tdata[15:0] == 16'h8000)
    else $error("saturated status without clamped coefficient");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[17:16] != 2'b11 && m_axis_tdata[23:18] == 6'b000000)
    else $error("bad status code or padding");

endmodule

bind ar1_coefficient_estimator_unit ar1ce_checker u_ar1ce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
